/* src/rpv_pkg.sv */
// rpv_pkg: shared types and character constants for the relative path validator.
// No dependencies; imported by rpv_seg_check, relative_path_validator and the test bench.
package rpv_pkg;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned SEG_LEN_W = 3;

  localparam logic [CFG_W-1:0]     MAX_LEN_RESET = 12'd512;
  localparam logic [COUNT_W-1:0]   COUNT_SAT     = 13'h1FFF;
  localparam logic [SEG_LEN_W-1:0] SEG_SAT       = 3'd5;
  localparam logic [SEG_LEN_W-1:0] PREFIX_BYTES  = 3'd4;

  localparam logic [7:0] CH_CTRL_LIM = 8'h20;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_Z    = 8'h7A;
  localparam logic [7:0] CH_BAR      = 8'h7C;
  localparam logic [7:0] CASE_DELTA  = 8'h20;

  // Device names, first character in the low byte
  localparam logic [23:0] NAME_CON = {"N", "O", "C"};
  localparam logic [23:0] NAME_PRN = {"N", "R", "P"};
  localparam logic [23:0] NAME_AUX = {"X", "U", "A"};
  localparam logic [23:0] NAME_NUL = {"L", "U", "N"};
  localparam logic [23:0] NAME_COM = {"M", "O", "C"};
  localparam logic [23:0] NAME_LPT = {"T", "P", "L"};

  // Running state of the current '/'-separated segment
  typedef struct packed {
    logic [SEG_LEN_W-1:0] seg_len;    // saturates at SEG_SAT
    logic [31:0]          prefix;     // first four bytes, upper-cased
    logic [SEG_LEN_W-1:0] stem_len;   // bytes before first '.'
    logic                 dot_seen;
    logic                 all_dots;
    logic [7:0]           last_char;
  } seg_state_t;

  localparam seg_state_t SEG_CLEAR = '{
    seg_len:   '0,
    prefix:    '0,
    stem_len:  '0,
    dot_seen:  1'b0,
    all_dots:  1'b1,
    last_char: '0
  };

endpackage

/* src/rpv_seg_check.sv */
// rpv_seg_check: decides whether a finished path segment is illegal.
// Depends on rpv_pkg (seg_state_t, device name constants).
module rpv_seg_check (
  input  rpv_pkg::seg_state_t seg,
  output logic                seg_bad
);
  import rpv_pkg::*;

  logic [23:0] head;
  logic [7:0]  digit;
  logic        name3_hit;
  logic        name4_hit;
  logic        whole_hit;
  logic        stem_hit;

  assign head  = seg.prefix[23:0];
  assign digit = seg.prefix[31:24];

  assign name3_hit = (head == NAME_CON) || (head == NAME_PRN) ||
                     (head == NAME_AUX) || (head == NAME_NUL);
  assign name4_hit = (digit >= CH_ONE) && (digit <= CH_NINE) &&
                     ((head == NAME_COM) || (head == NAME_LPT));

  assign whole_hit = ((seg.seg_len == 3'd3) && name3_hit) ||
                     ((seg.seg_len == 3'd4) && name4_hit);
  assign stem_hit  = ((seg.stem_len == 3'd3) && name3_hit) ||
                     ((seg.stem_len == 3'd4) && name4_hit);

  assign seg_bad = (seg.seg_len == '0) ||
                   (seg.all_dots && (seg.seg_len <= 3'd2)) ||
                   (seg.last_char == CH_DOT) || (seg.last_char == CH_SPACE) ||
                   whole_hit ||
                   (seg.dot_seen && stem_hit);

endmodule

/* src/relative_path_validator.sv */
// relative_path_validator: streaming validity check of a relative path.
// Depends on rpv_pkg and rpv_seg_check.
//
// A path arrives one byte per transfer on the in_ channel; in_is_last closes
// it and in_no_byte marks a transfer without a byte (with in_is_last: the
// path ends with what has been received, an empty path if nothing). Each
// path gives exactly one out_path_ok verdict on the out_ channel, 1 for a
// valid relative path. A path fails if it is empty, longer than
// max_path_length bytes, starts with '/', holds a control byte, backslash or
// any of < > : " | ? *, or has a segment that is empty, "." or "..", ends in
// '.' or space, or names a reserved device (CON PRN AUX NUL COM1-9 LPT1-9,
// case-blind) whole or in its stem before the first '.'. Bytes from 0x80 up
// are accepted. Throughput is one transfer per clock while the input does not
// stall: a transfer is held in an input register, checked in one pass against
// the running path state and the verdict captured in an output register, from
// which it is offered on the out_ channel. The input stalls only while a
// finished verdict waits in the output register, out_stall is high, and the
// next transfer in the input register also closes a path. The user must write
// max_path_length through cfg_wr_en/cfg_wr_data only while no path is in
// flight; the block itself does not enforce this. max_path_length resets to 512.
module relative_path_validator (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [rpv_pkg::CFG_W-1:0] cfg_wr_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_path_byte,
  input  logic                    in_is_last,
  input  logic                    in_no_byte,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_path_ok
);
  import rpv_pkg::*;

  // configuration register
  logic [CFG_W-1:0] max_len_r;

  // input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_none_r;

  // running path state
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic               path_failed_r, path_failed_nxt;
  logic               at_start_r, at_start_nxt;
  seg_state_t         seg_r, seg_nxt;
  seg_state_t         seg_upd;

  // result register
  logic out_v_r;
  logic path_ok_r;

  logic in_xfer;
  logic can_adv;
  logic s1_fire;
  logic take;
  logic is_slash;
  logic bad_char;
  logic cur_seg_bad;
  logic end_seg_bad;
  logic [7:0] up_char;
  logic verdict_ok;
  logic [COUNT_W-1:0] max_len_ext;

  // The input register moves on unless it holds a closing transfer and the
  // previous verdict is still waiting downstream.
  assign can_adv  = !s1_last_r || !out_v_r || !out_stall;
  assign s1_fire  = s1_v_r && can_adv;
  assign in_stall = s1_v_r && !can_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_path_byte;
      s1_last_r <= in_is_last;
      s1_none_r <= in_no_byte;
    end
  end

  // -------- per-byte checks --------
  assign take     = !s1_none_r;
  assign is_slash = (s1_byte_r == CH_SLASH);
  assign bad_char = (s1_byte_r < CH_CTRL_LIM) || (s1_byte_r == CH_LT) ||
                    (s1_byte_r == CH_GT) || (s1_byte_r == CH_COLON) ||
                    (s1_byte_r == CH_DQUOTE) || (s1_byte_r == CH_BAR) ||
                    (s1_byte_r == CH_QUEST) || (s1_byte_r == CH_STAR) ||
                    (s1_byte_r == CH_BSLASH);
  assign up_char  = ((s1_byte_r >= CH_LOW_A) && (s1_byte_r <= CH_LOW_Z)) ?
                    (s1_byte_r - CASE_DELTA) : s1_byte_r;

  // segment closed by a '/' is judged on its state before the slash
  rpv_seg_check u_cur_check (
    .seg     (seg_r),
    .seg_bad (cur_seg_bad)
  );

  // segment state after a non-slash byte
  always_comb begin
    seg_upd = seg_r;
    if (seg_r.seg_len < PREFIX_BYTES) begin
      case (seg_r.seg_len[1:0])
        2'd0:    seg_upd.prefix[7:0]   = up_char;
        2'd1:    seg_upd.prefix[15:8]  = up_char;
        2'd2:    seg_upd.prefix[23:16] = up_char;
        default: seg_upd.prefix[31:24] = up_char;
      endcase
    end
    if ((s1_byte_r == CH_DOT) && !seg_r.dot_seen) begin
      seg_upd.dot_seen = 1'b1;
      seg_upd.stem_len = seg_r.seg_len;
    end
    if (s1_byte_r != CH_DOT) begin
      seg_upd.all_dots = 1'b0;
    end
    seg_upd.last_char = s1_byte_r;
    if (seg_r.seg_len < SEG_SAT) begin
      seg_upd.seg_len = seg_r.seg_len + 3'd1;
    end
  end

  always_comb begin
    byte_count_nxt  = byte_count_r;
    path_failed_nxt = path_failed_r;
    at_start_nxt    = at_start_r;
    seg_nxt         = seg_r;
    if (take) begin
      if (byte_count_r != COUNT_SAT) begin
        byte_count_nxt = byte_count_r + 13'd1;
      end
      at_start_nxt = 1'b0;
      if ((at_start_r && is_slash) || bad_char || (is_slash && cur_seg_bad)) begin
        path_failed_nxt = 1'b1;
      end
      seg_nxt = is_slash ? SEG_CLEAR : seg_upd;
    end
  end

  // trailing segment is judged on its state after the closing byte
  rpv_seg_check u_end_check (
    .seg     (seg_nxt),
    .seg_bad (end_seg_bad)
  );

  assign max_len_ext = {1'b0, max_len_r};
  assign verdict_ok  = !path_failed_nxt && (byte_count_nxt != '0) &&
                       (byte_count_nxt <= max_len_ext) && !end_seg_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      path_failed_r <= 1'b0;
      at_start_r    <= 1'b1;
      seg_r         <= SEG_CLEAR;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        // verdict given: start a fresh path
        byte_count_r  <= '0;
        path_failed_r <= 1'b0;
        at_start_r    <= 1'b1;
        seg_r         <= SEG_CLEAR;
      end else begin
        byte_count_r  <= byte_count_nxt;
        path_failed_r <= path_failed_nxt;
        at_start_r    <= at_start_nxt;
        seg_r         <= seg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      path_ok_r <= verdict_ok;
    end
  end

  assign out_valid   = out_v_r;
  assign out_path_ok = path_ok_r;

  // -------- assertions --------
  // the path start flag and the byte count must agree
  a_start_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    at_start_r == (byte_count_r == '0))
    else $error("path start flag out of step with byte count");

  // an empty input register never stalls the source
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("stall raised with empty input register");

  // a closing transfer leaves a cleared path state behind
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (byte_count_r == '0) && !path_failed_r)
    else $error("path state not cleared after verdict");

  // a new verdict only follows a closing transfer
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_fire && s1_last_r))
    else $error("verdict without closing transfer");

  // segment length never passes its saturation point
  a_seg_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r.seg_len <= SEG_SAT)
    else $error("segment length beyond saturation");

endmodule

/* tb/relative_path_validator_test.sv */
// relative_path_validator_test: self-checking bench for the relative path validator.
// Depends on rpv_pkg and the relative_path_validator RTL. It drives paths a byte
// per transfer and checks each verdict against an in-bench path checker.
module relative_path_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpv_pkg::*;

  localparam int SETTLE_CYCLES  = 4;      // settling wait before a register write and at the end
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;   // cycles without any transfer

  typedef logic [7:0] byte_q_t [$];

  // One row of the directed table. Where known is set, ok is the verdict typed
  // in by hand; otherwise the path checker below supplies it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       nob;
    logic       known;
    logic       ok;
  } stim_row_t;

  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00,     1'b1, 1'b1, 1'b1, 1'b0},  // nothing at all: empty path
    '{8'hFF,     1'b0, 1'b1, 1'b0, 1'b0},  // byteless, not closing: ignored
    '{"a",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"b",       1'b1, 1'b0, 1'b1, 1'b1},  // "ab" is fine
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0},
    '{"a",       1'b1, 1'b0, 1'b1, 1'b0},  // absolute path
    '{8'h00,     1'b1, 1'b0, 1'b1, 1'b0},  // control byte
    '{8'hFF,     1'b1, 1'b0, 1'b1, 1'b1},  // top-bit bytes are allowed
    '{"c",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"o",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"N",       1'b1, 1'b0, 1'b1, 1'b0},  // device name, mixed case
    '{"L",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"p",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"t",       1'b0, 1'b0, 1'b0, 1'b0},
    '{"9",       1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{"x",       1'b1, 1'b0, 1'b0, 1'b0},  // device in the stem, left to the checker
    '{CH_DOT,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_DOT,    1'b1, 1'b0, 1'b1, 1'b0},  // ".."
    '{"a",       1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h7F,     1'b1, 1'b1, 1'b1, 1'b0},  // trailing slash, closed byteless
    '{CH_COLON,  1'b1, 1'b0, 1'b1, 1'b0},  // forbidden character
    '{"a",       1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SPACE,  1'b1, 1'b0, 1'b1, 1'b0},  // segment ends in a space
    '{CH_BSLASH, 1'b1, 1'b0, 1'b1, 1'b0}   // backslash
  };

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_wr_en    = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data  = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_path_byte = '0;
  logic                 in_is_last   = 1'b0;
  logic                 in_no_byte   = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_path_ok;

  relative_path_validator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_path_byte (in_path_byte),
    .in_is_last   (in_is_last),
    .in_no_byte   (in_no_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_path_ok  (out_path_ok)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Path checker: running state of the path under way, starting from reset.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] path_bytes    = '0;
  logic               path_bad      = 1'b0;
  logic               path_at_start = 1'b1;
  seg_state_t         seg           = SEG_CLEAR;
  logic [CFG_W-1:0]   path_max_len  = MAX_LEN_RESET;

  logic verdicts [$];  // verdicts still owed by the block, oldest first
  int   mismatches = 0;

  // Upper-cased leading bytes name a device: three letters, or COM/LPT plus 1-9
  function automatic logic is_device(input logic [SEG_LEN_W-1:0] n, input logic [31:0] pfx);
    if (n == 3'd3)
      return pfx[23:0] == NAME_CON || pfx[23:0] == NAME_PRN ||
             pfx[23:0] == NAME_AUX || pfx[23:0] == NAME_NUL;
    if (n == 3'd4)
      return pfx[31:24] >= CH_ONE && pfx[31:24] <= CH_NINE &&
             (pfx[23:0] == NAME_COM || pfx[23:0] == NAME_LPT);
    return 1'b0;
  endfunction

  function automatic logic segment_rejected(input seg_state_t s);
    return s.seg_len == '0 || (s.all_dots && s.seg_len <= 3'd2) ||
           s.last_char == CH_DOT || s.last_char == CH_SPACE ||
           is_device(s.seg_len, s.prefix) ||
           (s.dot_seen && is_device(s.stem_len, s.prefix));
  endfunction

  function automatic logic forbidden_char(input logic [7:0] c);
    return c < CH_CTRL_LIM || c == CH_LT || c == CH_GT || c == CH_COLON ||
           c == CH_DQUOTE || c == CH_BAR || c == CH_QUEST || c == CH_STAR ||
           c == CH_BSLASH;
  endfunction

  function automatic void take_path_byte(input logic [7:0] c);
    logic [7:0] up;
    if (path_bytes != COUNT_SAT) path_bytes++;
    if (path_at_start && c == CH_SLASH) path_bad = 1'b1;
    path_at_start = 1'b0;
    if (forbidden_char(c)) path_bad = 1'b1;
    if (c == CH_SLASH) begin
      if (segment_rejected(seg)) path_bad = 1'b1;
      seg = SEG_CLEAR;
      return;
    end
    up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_DELTA : c;
    if (seg.seg_len < PREFIX_BYTES) seg.prefix[8*seg.seg_len +: 8] = up;
    if (c == CH_DOT && !seg.dot_seen) begin
      seg.dot_seen = 1'b1;
      seg.stem_len = seg.seg_len;
    end
    if (c != CH_DOT) seg.all_dots = 1'b0;
    seg.last_char = c;
    if (seg.seg_len < SEG_SAT) seg.seg_len++;
  endfunction

  // Advance on one accepted transfer; returns 1 when it closes a path.
  function automatic logic path_transfer(input logic [7:0] c, input logic last,
                                         input logic nob, output logic ok);
    ok = 1'b0;
    if (!nob) take_path_byte(c);
    if (!last) return 1'b0;
    ok = !(path_bad || path_bytes == '0 || path_bytes > {1'b0, path_max_len} ||
           segment_rejected(seg));
    path_bytes    = '0;
    path_bad      = 1'b0;
    path_at_start = 1'b1;
    seg           = SEG_CLEAR;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Path generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_case(input logic [7:0] up);
    return $urandom_range(0, 1) ? up + CASE_DELTA : up;
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(8'h80, 8'hFF));
      1:       return CH_DOT;
      2:       return CH_SPACE;
      3:       return 8'($urandom_range(8'h30, 8'h39));
      4:       return $urandom_range(0, 1) ? 8'h2D : 8'h7F;  // '-' or DEL, both fine
      default: return any_case(8'($urandom_range(8'h41, 8'h5A)));
    endcase
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 9))
      0:       return CH_BSLASH;
      1:       return CH_COLON;
      2:       return CH_LT;
      3:       return CH_GT;
      4:       return CH_DQUOTE;
      5:       return CH_STAR;
      6:       return CH_QUEST;
      7:       return CH_BAR;
      default: return 8'($urandom_range(0, 8'h1F));
    endcase
  endfunction

  // Mostly well-formed paths of short segments, salted with device names,
  // dot segments, empty segments and the odd bad byte; a tenth pure noise.
  function automatic byte_q_t random_path(input int max_segs);
    byte_q_t    p;
    int         kind;
    int         nsegs;
    logic [23:0] dev;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) p.push_back(8'($urandom));
      return p;
    end
    if ($urandom_range(0, 19) == 0) p.push_back(CH_SLASH);
    nsegs = $urandom_range(1, max_segs);
    for (int s = 0; s < nsegs; s++) begin
      if (s != 0) p.push_back(CH_SLASH);
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1: begin
          case ($urandom_range(0, 5))
            0:       dev = NAME_CON;
            1:       dev = NAME_PRN;
            2:       dev = NAME_AUX;
            3:       dev = NAME_NUL;
            4:       dev = NAME_COM;
            default: dev = NAME_LPT;
          endcase
          p.push_back(any_case(dev[7:0]));
          p.push_back(any_case(dev[15:8]));
          p.push_back(any_case(dev[23:16]));
          if (dev == NAME_COM || dev == NAME_LPT)
            p.push_back(8'($urandom_range(8'h30, 8'h39)));
          case ($urandom_range(0, 3))
            0: begin
              p.push_back(CH_DOT);
              repeat ($urandom_range(0, 3)) p.push_back(plain_char());
            end
            1: p.push_back(plain_char());
            default: ;
          endcase
        end
        2: repeat ($urandom_range(1, 3)) p.push_back(CH_DOT);
        3: ;  // empty segment
        default: repeat ($urandom_range(1, 6)) p.push_back(plain_char());
      endcase
      if (kind > 3 && $urandom_range(0, 7) == 0)
        p.push_back($urandom_range(0, 1) ? CH_DOT : CH_SPACE);
    end
    if (p.size() != 0 && $urandom_range(0, 9) == 0)
      p[$urandom_range(0, p.size() - 1)] = bad_char();
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: payload changes on the falling edge, transfer seen on the rising one
  // ---------------------------------------------------------------------------
  logic tx_burst = 1'b0;

  task automatic send_transfer(input logic [7:0] c, input logic last, input logic nob,
                               input logic known, input logic known_ok);
    logic ok;
    int   gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_path_byte <= c;
    in_is_last   <= last;
    in_no_byte   <= nob;
    do @(posedge clk); while (in_stall);
    if (path_transfer(c, last, nob, ok))
      verdicts.push_back(known ? known_ok : ok);
    // Gap before the next transfer; bursts switch idling off for a while
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Counted transfers exclude the byteless fillers that the block just drops
  task automatic send_path(input byte_q_t p, inout int sent);
    logic tail_nob;
    tail_nob = p.size() == 0 || $urandom_range(0, 4) == 0;
    foreach (p[i]) begin
      if ($urandom_range(0, 19) == 0) send_transfer(8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
      send_transfer(p[i], i == p.size() - 1 && !tail_nob, 1'b0, 1'b0, 1'b0);
      sent++;
    end
    if (tail_nob) begin
      send_transfer(8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0);
      sent++;
    end
  endtask

  task automatic random_phase(input int items, input int max_segs);
    int sent;
    sent = 0;
    while (sent < items) send_path(random_path(max_segs), sent);
  endtask

  // One lowercase segment of n bytes, for the length limits
  task automatic send_long_path(input int n);
    byte_q_t p;
    int      sent;
    sent = 0;
    repeat (n) p.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
    send_path(p, sent);
  endtask

  // Register write only with the block idle: input quiet, verdicts all in, and
  // a settling wait for a byteless transfer still in the pipe
  task automatic set_max_len(input logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    path_max_len  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall per verdict; on request holds off for a long spell
  // ---------------------------------------------------------------------------
  logic rx_burst  = 1'b0;
  logic rx_took   = 1'b0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   rx_wait   = 0;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_took) begin
      rx_took = 1'b0;
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict check and watchdog
  // ---------------------------------------------------------------------------
  int   idle_cycles = 0;
  logic want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_took = 1'b1;
      if (verdicts.size() == 0) begin
        $display("%0t ns: verdict with none outstanding: expected none, actual %0b",
                 $realtime, out_path_ok);
        mismatches++;
      end else begin
        want = verdicts.pop_front();
        if (out_path_ok !== want) begin
          $display("%0t ns: path_ok mismatch: expected %0b, actual %0b",
                   $realtime, want, out_path_ok);
          mismatches++;
        end
      end
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, limit still at its reset value
    for (int i = 0; i < DIR_ROWS; i++)
      send_transfer(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].nob,
                    DIRECTED[i].known, DIRECTED[i].ok);
    random_phase(50, 3);

    // Limit of one: only single-byte paths can pass
    set_max_len(12'd1);
    random_phase(50, 2);

    // Largest limit
    set_max_len(12'd4095);
    random_phase(50, 4);

    // A path right at the limit, then one a byte over it
    set_max_len(12'd32);
    send_long_path(32);
    send_long_path(33);

    // Zero: every path with a byte is too long
    set_max_len(12'd0);
    random_phase(30, 2);

    // Short paths while the receiver holds off, so the block backs up
    set_max_len(12'd6);
    @(posedge clk);
    hold_req = 1'b1;
    random_phase(120, 1);

    set_max_len(12'($urandom_range(7, 40)));
    random_phase(120, 4);

    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
